FILE: hw/rtl/skf_pkg.sv
// Shared types, widths and constants for the scalar Kalman pressure filter.
// Used by the interfaces, the register file, the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

    localparam int CHANNELS = 2;
    localparam int CH_W     = 1;
    localparam int MEAS_W   = 48;
    localparam int VAR_W    = 32;
    localparam int GAIN_W   = 17;
    localparam int TICK_W   = 16;
    localparam int SUM_W    = VAR_W + 1;
    localparam int DIFF_W   = MEAS_W + 1;
    localparam int REM_W    = SUM_W + 1;
    localparam int ACC_W    = DIFF_W + GAIN_W;
    localparam int PPROD_W  = VAR_W + GAIN_W;
    localparam int FRAC_W   = 16;
    localparam int STEP_W   = $clog2(GAIN_W);

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);
    localparam logic [TICK_W-1:0] TICK_MAX = '1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(GAIN_W - 1);

    localparam logic [VAR_W-1:0]  RST_MEASURE_VAR = VAR_W'(26214);
    localparam logic [VAR_W-1:0]  RST_START_VAR   = VAR_W'(26214);
    localparam logic [MEAS_W-1:0] RST_START_EST   = MEAS_W'(64'd6640435200);
    localparam logic [TICK_W-1:0] RST_SETTLE      = TICK_W'(10);

    localparam int APB_AW    = 5;
    localparam int APB_DW    = 64;
    localparam int REG_IDX_W = 2;
    localparam int REG_LSB   = 3;

    localparam logic [REG_IDX_W-1:0] REG_MEASURE_VAR = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_START_VAR   = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_START_EST   = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_SETTLE      = REG_IDX_W'(3);

    typedef struct packed {
        logic [VAR_W-1:0]  measure_variance;
        logic [VAR_W-1:0]  start_variance;
        logic [MEAS_W-1:0] start_estimate;
        logic [TICK_W-1:0] settle_count;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_PROD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul_step;
        logic prod;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_ch_ok;
        logic in_restart;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: hw/rtl/skf_if.sv
// Valid/ready channel interfaces for the filter's input items and result items.
// Depends on skf_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface skf_in_if;
    logic                             valid;
    logic                             ready;
    logic [skf_pkg::CH_W-1:0]         channel;
    logic signed [skf_pkg::MEAS_W-1:0] measurement;
    logic                             restart;

    modport source (output valid, output channel, output measurement, output restart,
                    input ready);
    modport sink (input valid, input channel, input measurement, input restart,
                  output ready);
endinterface

interface skf_out_if;
    logic                              valid;
    logic                              ready;
    logic [skf_pkg::CH_W-1:0]          out_channel;
    logic signed [skf_pkg::MEAS_W-1:0] filtered;
    logic [skf_pkg::GAIN_W-1:0]        gain;
    logic [skf_pkg::VAR_W-1:0]         variance;
    logic [skf_pkg::TICK_W-1:0]        updates;
    logic                              converged;

    modport source (output valid, output out_channel, output filtered, output gain,
                    output variance, output updates, output converged, input ready);
    modport sink (input valid, input out_channel, input filtered, input gain,
                  input variance, input updates, input converged, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/skf_cfg.sv
// APB-style configuration register file of the Kalman pressure filter.
// Depends on skf_pkg for the register map and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module skf_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [skf_pkg::APB_AW-1:0] paddr,
    input  logic [skf_pkg::APB_DW-1:0] pwdata,
    output logic [skf_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output skf_pkg::t_cfg              o_cfg
);

    skf_pkg::t_cfg                    r_cfg;
    logic [skf_pkg::REG_IDX_W-1:0]    w_idx;
    logic                             w_write;

    assign w_idx   = paddr[skf_pkg::APB_AW-1:skf_pkg::REG_LSB];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.measure_variance <= skf_pkg::RST_MEASURE_VAR;
            r_cfg.start_variance   <= skf_pkg::RST_START_VAR;
            r_cfg.start_estimate   <= skf_pkg::RST_START_EST;
            r_cfg.settle_count     <= skf_pkg::RST_SETTLE;
        end else if (w_write) begin
            case (w_idx)
                skf_pkg::REG_MEASURE_VAR: begin
                    r_cfg.measure_variance <= pwdata[skf_pkg::VAR_W-1:0];
                end
                skf_pkg::REG_START_VAR: begin
                    r_cfg.start_variance <= pwdata[skf_pkg::VAR_W-1:0];
                end
                skf_pkg::REG_START_EST: begin
                    r_cfg.start_estimate <= pwdata[skf_pkg::MEAS_W-1:0];
                end
                skf_pkg::REG_SETTLE: begin
                    r_cfg.settle_count <= pwdata[skf_pkg::TICK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            skf_pkg::REG_MEASURE_VAR: prdata = skf_pkg::APB_DW'(r_cfg.measure_variance);
            skf_pkg::REG_START_VAR:   prdata = skf_pkg::APB_DW'(r_cfg.start_variance);
            skf_pkg::REG_START_EST:   prdata = skf_pkg::APB_DW'(r_cfg.start_estimate);
            skf_pkg::REG_SETTLE:      prdata = skf_pkg::APB_DW'(r_cfg.settle_count);
            default:                  prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/skf_ctrl.sv
// Controller of the Kalman pressure filter: sequences load, divide, multiply and commit.
// Depends on skf_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module skf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  skf_pkg::t_dp_stat   i_stat,
    output skf_pkg::t_dp_cmd    o_cmd
);

    skf_pkg::t_state               r_state;
    skf_pkg::t_state               n_state;
    logic [skf_pkg::STEP_W-1:0]    r_cnt;
    logic [skf_pkg::STEP_W-1:0]    n_cnt;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic                          w_slot_free;
    logic                          w_last;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_last      = (r_cnt == skf_pkg::STEP_LAST);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skf_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            skf_pkg::ST_IDLE: begin
                if (i_in_valid && i_stat.in_ch_ok) begin
                    n_state = i_stat.in_restart ? skf_pkg::ST_DONE : skf_pkg::ST_DIV;
                end
            end
            skf_pkg::ST_DIV: begin
                if (w_last) begin
                    n_state = skf_pkg::ST_MUL;
                end
            end
            skf_pkg::ST_MUL: begin
                if (w_last) begin
                    n_state = skf_pkg::ST_PROD;
                end
            end
            skf_pkg::ST_PROD: begin
                n_state = skf_pkg::ST_DONE;
            end
            skf_pkg::ST_DONE: begin
                if (w_slot_free) begin
                    n_state = skf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = skf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        n_cnt      = '0;
        case (r_state)
            skf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid && i_stat.in_ch_ok;
            end
            skf_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = w_last ? '0 : r_cnt + 1'b1;
            end
            skf_pkg::ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = w_last ? '0 : r_cnt + 1'b1;
            end
            skf_pkg::ST_PROD: begin
                o_cmd.prod = 1'b1;
            end
            skf_pkg::ST_DONE: begin
                o_cmd.commit = w_slot_free;
            end
            default: begin
            end
        endcase
        n_out_valid = o_cmd.commit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

endmodule

`default_nettype wire

FILE: hw/rtl/skf_dp.sv
// Datapath of the Kalman pressure filter: channel state, serial divider for the gain,
// serial multiplier for the estimate update and the result register. Depends on skf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skf_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  skf_pkg::t_cfg                     i_cfg,
    input  skf_pkg::t_dp_cmd                  i_cmd,
    output skf_pkg::t_dp_stat                 o_stat,
    input  logic [skf_pkg::CH_W-1:0]          i_channel,
    input  logic signed [skf_pkg::MEAS_W-1:0] i_measurement,
    input  logic                              i_restart,
    output logic [skf_pkg::CH_W-1:0]          o_out_channel,
    output logic signed [skf_pkg::MEAS_W-1:0] o_filtered,
    output logic [skf_pkg::GAIN_W-1:0]        o_gain,
    output logic [skf_pkg::VAR_W-1:0]         o_variance,
    output logic [skf_pkg::TICK_W-1:0]        o_updates,
    output logic                              o_converged
);

    logic [skf_pkg::MEAS_W-1:0]  r_est_store  [skf_pkg::CHANNELS];
    logic [skf_pkg::VAR_W-1:0]   r_var_store  [skf_pkg::CHANNELS];
    logic [skf_pkg::GAIN_W-1:0]  r_gain_store [skf_pkg::CHANNELS];
    logic [skf_pkg::TICK_W-1:0]  r_tick_store [skf_pkg::CHANNELS];

    logic [skf_pkg::CH_W-1:0]    r_ch;
    logic                        r_restart;
    logic [skf_pkg::MEAS_W-1:0]  r_x;
    logic [skf_pkg::VAR_W-1:0]   r_p;
    logic [skf_pkg::SUM_W-1:0]   r_sum;
    logic [skf_pkg::DIFF_W-1:0]  r_diff;
    logic [skf_pkg::REM_W-1:0]   r_rem;
    logic [skf_pkg::GAIN_W-1:0]  r_dvd;
    logic [skf_pkg::GAIN_W-1:0]  r_q;
    logic [skf_pkg::ACC_W-1:0]   r_acc;
    logic [skf_pkg::MEAS_W-1:0]  r_x_new;
    logic [skf_pkg::VAR_W-1:0]   r_p_new;
    logic [skf_pkg::GAIN_W-1:0]  r_gain_new;

    logic [skf_pkg::MEAS_W-1:0]  w_x_rd;
    logic [skf_pkg::VAR_W-1:0]   w_p_rd;
    logic [skf_pkg::REM_W-1:0]   w_rem_sh;
    logic                        w_fits;
    logic                        w_sum_zero;
    logic [skf_pkg::GAIN_W-1:0]  w_gain;
    logic [skf_pkg::GAIN_W-1:0]  w_one_minus;
    logic [skf_pkg::ACC_W-1:0]   w_mext;
    logic [skf_pkg::ACC_W-1:0]   w_addend;
    logic [skf_pkg::PPROD_W-1:0] w_prod_p;
    logic [skf_pkg::TICK_W-1:0]  w_tick;
    logic [skf_pkg::TICK_W-1:0]  w_tick_next;
    logic [skf_pkg::MEAS_W-1:0]  w_est_out;
    logic [skf_pkg::VAR_W-1:0]   w_var_out;
    logic [skf_pkg::GAIN_W-1:0]  w_gain_out;
    logic [skf_pkg::TICK_W-1:0]  w_tick_out;

    assign o_stat.in_ch_ok   = (int'(i_channel) < skf_pkg::CHANNELS);
    assign o_stat.in_restart = i_restart;

    assign w_x_rd = r_est_store[i_channel];
    assign w_p_rd = r_var_store[i_channel];

    // Restoring division of P * 2^16 by P + R, one quotient bit per step.
    assign w_rem_sh   = {r_rem[skf_pkg::REM_W-2:0], r_dvd[skf_pkg::GAIN_W-1]};
    assign w_fits     = (w_rem_sh >= skf_pkg::REM_W'(r_sum));
    assign w_sum_zero = (r_sum == '0);
    assign w_gain     = w_sum_zero ? '0 : r_q;

    // The gain is rotated MSB first through r_q while the product builds up.
    assign w_mext   = {{(skf_pkg::ACC_W - skf_pkg::DIFF_W){r_diff[skf_pkg::DIFF_W-1]}}, r_diff};
    assign w_addend = (r_q[skf_pkg::GAIN_W-1] && !w_sum_zero) ? w_mext : '0;

    assign w_one_minus = skf_pkg::GAIN_ONE - w_gain;
    assign w_prod_p    = skf_pkg::PPROD_W'(w_one_minus) * skf_pkg::PPROD_W'(r_p);

    assign w_tick      = r_tick_store[r_ch];
    assign w_tick_next = (w_tick == skf_pkg::TICK_MAX) ? w_tick : w_tick + 1'b1;

    assign w_est_out  = r_restart ? i_cfg.start_estimate : r_x_new;
    assign w_var_out  = r_restart ? i_cfg.start_variance : r_p_new;
    assign w_gain_out = r_restart ? skf_pkg::GAIN_ONE : r_gain_new;
    assign w_tick_out = r_restart ? '0 : w_tick_next;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch      <= i_channel;
            r_restart <= i_restart;
            r_x       <= w_x_rd;
            r_p       <= w_p_rd;
            r_sum     <= skf_pkg::SUM_W'(w_p_rd) + skf_pkg::SUM_W'(i_cfg.measure_variance);
            r_diff    <= {i_measurement[skf_pkg::MEAS_W-1], i_measurement}
                         - {w_x_rd[skf_pkg::MEAS_W-1], w_x_rd};
            r_rem     <= skf_pkg::REM_W'(w_p_rd[skf_pkg::VAR_W-1:1]);
            r_dvd     <= {w_p_rd[0], {(skf_pkg::GAIN_W - 1){1'b0}}};
            r_q       <= '0;
            r_acc     <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_fits ? (w_rem_sh - skf_pkg::REM_W'(r_sum)) : w_rem_sh;
            r_dvd <= {r_dvd[skf_pkg::GAIN_W-2:0], 1'b0};
            r_q   <= {r_q[skf_pkg::GAIN_W-2:0], w_fits};
        end
        if (i_cmd.mul_step) begin
            r_acc <= {r_acc[skf_pkg::ACC_W-2:0], 1'b0} + w_addend;
            r_q   <= {r_q[skf_pkg::GAIN_W-2:0], r_q[skf_pkg::GAIN_W-1]};
        end
        if (i_cmd.prod) begin
            r_x_new    <= r_x + r_acc[skf_pkg::FRAC_W+skf_pkg::MEAS_W-1:skf_pkg::FRAC_W];
            r_p_new    <= w_prod_p[skf_pkg::FRAC_W+skf_pkg::VAR_W-1:skf_pkg::FRAC_W];
            r_gain_new <= w_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < skf_pkg::CHANNELS; i++) begin
                r_est_store[i]  <= skf_pkg::RST_START_EST;
                r_var_store[i]  <= skf_pkg::RST_START_VAR;
                r_gain_store[i] <= skf_pkg::GAIN_ONE;
                r_tick_store[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            r_est_store[r_ch]  <= w_est_out;
            r_var_store[r_ch]  <= w_var_out;
            r_gain_store[r_ch] <= w_gain_out;
            r_tick_store[r_ch] <= w_tick_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_out_channel <= r_ch;
            o_filtered    <= $signed(w_est_out);
            o_gain        <= w_gain_out;
            o_variance    <= w_var_out;
            o_updates     <= w_tick_out;
            o_converged   <= (w_tick_out > i_cfg.settle_count);
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/scalar_kalman_pressure_filter.sv
// Top level of the scalar Kalman pressure filter: register file, controller and datapath.
// Depends on skf_pkg, skf_if, skf_cfg, skf_ctrl and skf_dp.
`timescale 1ns / 1ps
`default_nettype none

// Two-channel fixed-point Kalman filter without process noise. Each input item updates
// one channel with a Q32.16 measurement, or reloads it from the start registers when
// restart is set, and yields one result item with the new estimate, gain, variance,
// update count and converged flag. An update item passes from acceptance through the
// serial restoring divider that forms the gain one quotient bit per cycle, the serial
// multiplier that applies the gain one bit per cycle and the product step to a valid
// result; a restart item goes from acceptance straight to its result. Once a result
// enters the output register the next item is accepted while the result waits to be taken.
// Configuration registers sit at byte addresses 0, 8, 16 and 24 of the 64-bit APB port.
module scalar_kalman_pressure_filter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    skf_in_if.sink                     i_in,
    skf_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [skf_pkg::APB_AW-1:0] paddr,
    input  logic [skf_pkg::APB_DW-1:0] pwdata,
    output logic [skf_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    skf_pkg::t_cfg     w_cfg;
    skf_pkg::t_dp_cmd  w_cmd;
    skf_pkg::t_dp_stat w_stat;
    logic              w_in_ready;
    logic              w_out_valid;

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    skf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    skf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    skf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_channel     (i_in.channel),
        .i_measurement (i_in.measurement),
        .i_restart     (i_in.restart),
        .o_out_channel (o_out.out_channel),
        .o_filtered    (o_out.filtered),
        .o_gain        (o_out.gain),
        .o_variance    (o_out.variance),
        .o_updates     (o_out.updates),
        .o_converged   (o_out.converged)
    );

endmodule

`default_nettype wire
